### sv/clb_pkg.sv
// Package with the shared constants and types of the character-LCD bus writer.
`timescale 1ns / 1ps

package clb_pkg;

    // Display geometry.
    localparam int LINE_LENGTH = 16;
    localparam int POS_W       = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT    = 2'd1;

    // Request codes on the func field.
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_CMD   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_CHAR  = 2'd3;

    // Controller command bytes.
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_FSET_8B_1L = 8'h30;
    localparam logic [7:0] CMD_FSET_8B_2L = 8'h38;
    localparam logic [7:0] CMD_FSET_4B_1L = 8'h20;
    localparam logic [7:0] CMD_FSET_4B_2L = 8'h28;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_HOME_LINE1 = 8'h80;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0E;
    localparam logic [7:0] CMD_LINE2      = 8'hC0;
    localparam logic [7:0] LONG_LIMIT     = 8'h04;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic       four_bit_mode;
        logic [1:0] line_count;
    } cfg_t;

    // One byte transfer waiting in the queue.
    typedef struct packed {
        logic       reg_select;
        logic [7:0] data;
        logic       long_settle;
        logic       pause_before;
        logic       last;
    } byte_entry_t;

endpackage

### sv/clb_if.sv
// Interfaces for the request channel and the bus transfer channel.
`timescale 1ns / 1ps

interface clb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface clb_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_value;
    logic       long_settle;
    logic       pause_before;
    logic       last;

    modport source (output valid, output reg_select, output bus_value, output long_settle,
                    output pause_before, output last, input ready);
    modport sink (input valid, input reg_select, input bus_value, input long_settle,
                  input pause_before, input last, output ready);
endinterface

### sv/clb_front.sv
// Front part: accepts requests, tracks the cursor position and emits byte transfers.
`timescale 1ns / 1ps

module clb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clb_pkg::cfg_t        cfg,
    clb_req_if.sink              req,
    output logic                 push,
    output clb_pkg::byte_entry_t push_entry,
    input  logic                 push_ready
);

    // Kinds of byte sequence the front can be working through.
    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_CMD        = 3'd1;
    localparam logic [2:0] OP_START      = 3'd2;
    localparam logic [2:0] OP_CHAR       = 3'd3;
    localparam logic [2:0] OP_CHAR_WRAP  = 3'd4;
    localparam logic [2:0] OP_CHAR_LINE2 = 3'd5;

    localparam int POS_W_L = clb_pkg::POS_W;

    logic             busy_reg, busy_next;
    logic [2:0]       op_reg, op_next;
    logic [7:0]       value_reg, value_next;
    logic [2:0]       step_reg, step_next;
    logic [POS_W_L-1:0] pos_reg, pos_next;

    logic             accept;
    logic             one_line;
    logic             last_step;
    logic [7:0]       fset;
    logic [7:0]       byte_val;
    logic             rs;
    logic [POS_W_L:0] pos_inc;
    logic [POS_W_L:0] full_mark;
    logic [2:0]       char_op;

    assign one_line = (cfg.line_count == 2'd1);

    // Function set byte from bus width and line count.
    always_comb
    begin
        if (cfg.four_bit_mode)
            fset = one_line ? clb_pkg::CMD_FSET_4B_1L : clb_pkg::CMD_FSET_4B_2L;
        else
            fset = one_line ? clb_pkg::CMD_FSET_8B_1L : clb_pkg::CMD_FSET_8B_2L;
    end

    // Byte for the current step of the current sequence.
    always_comb
    begin
        byte_val  = clb_pkg::CMD_CLEAR;
        rs        = 1'b0;
        last_step = 1'b1;
        case (op_reg)
            OP_INIT:
            begin
                last_step = (step_reg == 3'd4);
                case (step_reg)
                    3'd0:    byte_val = clb_pkg::CMD_CLEAR;
                    3'd1:    byte_val = fset;
                    3'd2:    byte_val = clb_pkg::CMD_ENTRY_MODE;
                    3'd3:    byte_val = clb_pkg::CMD_HOME_LINE1;
                    default: byte_val = clb_pkg::CMD_DISPLAY_ON;
                endcase
            end
            OP_CMD:
            begin
                byte_val = value_reg;
            end
            OP_START:
            begin
                byte_val = clb_pkg::CMD_CLEAR;
            end
            OP_CHAR_WRAP:
            begin
                last_step = (step_reg == 3'd2);
                case (step_reg)
                    3'd0:
                    begin
                        byte_val = value_reg;
                        rs       = 1'b1;
                    end
                    3'd1:    byte_val = clb_pkg::CMD_CLEAR;
                    default: byte_val = clb_pkg::CMD_HOME_LINE1;
                endcase
            end
            OP_CHAR_LINE2:
            begin
                last_step = (step_reg == 3'd1);
                if (step_reg == 3'd0)
                begin
                    byte_val = value_reg;
                    rs       = 1'b1;
                end
                else
                begin
                    byte_val = clb_pkg::CMD_LINE2;
                end
            end
            default:
            begin
                byte_val = value_reg;
                rs       = 1'b1;
            end
        endcase
    end

    // Queue entry for the current step.
    always_comb
    begin
        push_entry.reg_select   = rs;
        push_entry.data         = byte_val;
        push_entry.long_settle  = !rs && (byte_val < clb_pkg::LONG_LIMIT);
        push_entry.pause_before = (op_reg == OP_CHAR_WRAP) && (step_reg == 3'd1);
        push_entry.last         = last_step;
    end

    assign push       = busy_reg;
    assign req.ready  = !busy_reg || (push_ready && last_step);
    assign accept     = req.valid && req.ready;

    // Cursor bookkeeping for a character.
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign full_mark = one_line ? (POS_W_L+1)'(clb_pkg::LINE_LENGTH)
                                : (POS_W_L+1)'(2 * clb_pkg::LINE_LENGTH);

    always_comb
    begin
        if (pos_inc >= full_mark)
            char_op = OP_CHAR_WRAP;
        else if (!one_line && pos_inc == (POS_W_L+1)'(clb_pkg::LINE_LENGTH))
            char_op = OP_CHAR_LINE2;
        else
            char_op = OP_CHAR;
    end

    // Sequencer next state.
    always_comb
    begin
        busy_next  = busy_reg;
        op_next    = op_reg;
        value_next = value_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            value_next = req.value;
            step_next  = 3'd0;
            case (req.func)
                clb_pkg::FUNC_INIT:  op_next = OP_INIT;
                clb_pkg::FUNC_CMD:   op_next = OP_CMD;
                clb_pkg::FUNC_START:
                begin
                    op_next  = OP_START;
                    pos_next = '0;
                end
                default:
                begin
                    op_next  = char_op;
                    pos_next = (char_op == OP_CHAR_WRAP) ? '0 : pos_inc[POS_W_L-1:0];
                end
            endcase
        end
        else if (busy_reg && push_ready)
        begin
            if (last_step)
                busy_next = 1'b0;
            else
                step_next = step_reg + 3'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= OP_CMD;
            step_reg <= 3'd0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            step_reg <= step_next;
            pos_reg  <= pos_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### sv/clb_queue.sv
// Short queue of byte transfers between the front and back parts.
`timescale 1ns / 1ps

module clb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  clb_pkg::byte_entry_t push_entry,
    output logic                 push_ready,
    output logic                 head_valid,
    output clb_pkg::byte_entry_t head_entry,
    input  logic                 pop
);

    clb_pkg::byte_entry_t        mem_reg [clb_pkg::QUEUE_DEPTH];
    logic [clb_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [clb_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [clb_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != clb_pkg::QCNT_W'(clb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= clb_pkg::QCNT_W'(clb_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // An empty queue has its pointers together.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

    // A push without a pop grows the queue by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

### sv/clb_back.sv
// Back part: splits queued bytes into bus beats and holds the output register.
`timescale 1ns / 1ps

module clb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clb_pkg::cfg_t        cfg,
    input  logic                 head_valid,
    input  clb_pkg::byte_entry_t head_entry,
    output logic                 pop,
    clb_xfer_if.source           xfer
);

    logic       out_valid_reg, out_valid_next;
    logic       phase_reg, phase_next;
    logic       rs_reg, rs_next;
    logic [7:0] bus_reg, bus_next;
    logic       long_reg, long_next;
    logic       pause_reg, pause_next;
    logic       last_reg, last_next;
    logic       load;

    // The output register takes a new beat when empty or being drained.
    assign load = !out_valid_reg || xfer.ready;

    always_comb
    begin
        pop            = 1'b0;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !xfer.ready;
        rs_next        = rs_reg;
        bus_next       = bus_reg;
        long_next      = long_reg;
        pause_next     = pause_reg;
        last_next      = last_reg;
        if (load && head_valid)
        begin
            out_valid_next = 1'b1;
            rs_next        = head_entry.reg_select;
            long_next      = head_entry.long_settle;
            if (cfg.four_bit_mode && !phase_reg)
            begin
                // High nibble first; the byte stays at the queue head.
                bus_next   = {head_entry.data[7:4], 4'h0};
                pause_next = head_entry.pause_before;
                last_next  = 1'b0;
                phase_next = 1'b1;
            end
            else if (cfg.four_bit_mode)
            begin
                bus_next   = {head_entry.data[3:0], 4'h0};
                pause_next = 1'b0;
                last_next  = head_entry.last;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
            else
            begin
                bus_next   = head_entry.data;
                pause_next = head_entry.pause_before;
                last_next  = head_entry.last;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Beat payload.
    always_ff @(posedge clk)
    begin
        rs_reg    <= rs_next;
        bus_reg   <= bus_next;
        long_reg  <= long_next;
        pause_reg <= pause_next;
        last_reg  <= last_next;
    end

    assign xfer.valid        = out_valid_reg;
    assign xfer.reg_select   = rs_reg;
    assign xfer.bus_value    = bus_reg;
    assign xfer.long_settle  = long_reg;
    assign xfer.pause_before = pause_reg;
    assign xfer.last         = last_reg;

endmodule

### sv/char_lcd_bus_writer.sv
// Top level of the character-LCD bus writer.
//
// Requests arrive on req (func, value) and leave as bus beats on xfer, one beat per
// controller transfer: register select, bus value, long settle, pause flag and a
// last flag on the final beat of each request. Both channels use valid/ready.
// Configuration (four_bit_mode, line_count) is written through cfg_we, cfg_index
// and cfg_data; the block leaves it to the user to write it only while no request is in flight.
// A front sequencer emits one byte per cycle into a four-entry queue while it has
// room; the back part turns each byte into one beat, or two nibble beats in 4-bit
// mode, and holds it in an output register. The back part sets the rate: one beat
// per cycle while the receiver is ready. A request has 1 to 10 beats; after
// acceptance its first byte passes from the front through the queue into the
// output register. A new request is accepted in the cycle the front sends the
// last byte of the previous one. Reset clears the cursor position, empties the
// queue, sets 8-bit mode and two lines. When the receiver stalls, the output
// beat holds, the queue fills, and req.ready drops once the queue is full.
`timescale 1ns / 1ps

module char_lcd_bus_writer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    clb_req_if.sink                              req,
    clb_xfer_if.source                           xfer,
    input  logic                                 cfg_we,
    input  logic [clb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [clb_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic                 four_bit_reg;
    logic [1:0]           line_count_reg;
    clb_pkg::cfg_t        cfg;
    logic                 push;
    logic                 push_ready;
    clb_pkg::byte_entry_t push_entry;
    logic                 head_valid;
    clb_pkg::byte_entry_t head_entry;
    logic                 pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg   <= 1'b0;
            line_count_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clb_pkg::REG_FOUR_BIT_MODE: four_bit_reg   <= cfg_data[0];
                clb_pkg::REG_LINE_COUNT:    line_count_reg <= cfg_data[1:0];
                default:                    ;
            endcase
        end
    end

    assign cfg.four_bit_mode = four_bit_reg;
    assign cfg.line_count    = line_count_reg;

    clb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    clb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    clb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .xfer       (xfer)
    );

endmodule

### bench/char_lcd_bus_writer_tb.sv
// Self-checking testbench for the character-LCD bus writer: requests in, bus beats checked.
`timescale 1ns / 1ps

module char_lcd_bus_writer_tb;

    // Register indexes that map to no register; writes to them must change nothing.
    localparam logic [clb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [clb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 120;
    localparam int PHASE_ITEMS  = 28;
    localparam int NUM_PHASES   = 8;

    // One request as queued for the sender.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] value;
    } lcd_request_t;

    // One bus beat as the block should produce it.
    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic       long_settle;
        logic       pause_before;
        logic       last;
    } lcd_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                           cfg_we;
    logic [clb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [clb_pkg::CFG_DATA_W-1:0] cfg_data;

    clb_req_if  req_ch ();
    clb_xfer_if xfer_ch ();

    char_lcd_bus_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .xfer      (xfer_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration and the cursor position.
    logic                      cfg_four_bit = 1'b0;
    logic [1:0]                cfg_lines    = 2'd2;
    logic [clb_pkg::POS_W-1:0] cursor_pos   = '0;

    lcd_request_t reqs_to_send[$];
    lcd_beat_t    beats_due[$];

    int  mismatches    = 0;
    int  reqs_accepted = 0;
    int  gap_pct       = 0;
    int  stall_pct     = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    logic hold_done    = 1'b0;
    logic req_fire     = 1'b0;

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Queue the beats of one byte: whole, or as two nibbles high first.
    function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic pause);
        lcd_beat_t bt;
        bt.reg_select   = rs;
        bt.long_settle  = (rs == 1'b0) && (b < clb_pkg::LONG_LIMIT);
        bt.pause_before = pause;
        bt.last         = 1'b0;
        if (cfg_four_bit)
        begin
            bt.bus_value = b & 8'hF0;
            beats_due.push_back(bt);
            bt.bus_value    = {b[3:0], 4'h0};
            bt.pause_before = 1'b0;
            beats_due.push_back(bt);
        end
        else
        begin
            bt.bus_value = b;
            beats_due.push_back(bt);
        end
    endfunction

    // Work out every beat that one request causes and update the cursor.
    function automatic void predict_request(input logic [1:0] func, input logic [7:0] value);
        logic       one_line;
        logic [5:0] next_pos;
        logic [5:0] screen_end;
        logic [7:0] fset;
        lcd_beat_t  tail;
        one_line = (cfg_lines == 2'd1);
        case (func)
            clb_pkg::FUNC_INIT:
            begin
                if (cfg_four_bit)
                    fset = one_line ? clb_pkg::CMD_FSET_4B_1L : clb_pkg::CMD_FSET_4B_2L;
                else
                    fset = one_line ? clb_pkg::CMD_FSET_8B_1L : clb_pkg::CMD_FSET_8B_2L;
                queue_byte(1'b0, clb_pkg::CMD_CLEAR, 1'b0);
                queue_byte(1'b0, fset, 1'b0);
                queue_byte(1'b0, clb_pkg::CMD_ENTRY_MODE, 1'b0);
                queue_byte(1'b0, clb_pkg::CMD_HOME_LINE1, 1'b0);
                queue_byte(1'b0, clb_pkg::CMD_DISPLAY_ON, 1'b0);
            end
            clb_pkg::FUNC_CMD:
                queue_byte(1'b0, value, 1'b0);
            clb_pkg::FUNC_START:
            begin
                queue_byte(1'b0, clb_pkg::CMD_CLEAR, 1'b0);
                cursor_pos = '0;
            end
            clb_pkg::FUNC_CHAR:
            begin
                next_pos   = {1'b0, cursor_pos} + 6'd1;
                screen_end = one_line ? 6'(clb_pkg::LINE_LENGTH)
                                      : 6'(2 * clb_pkg::LINE_LENGTH);
                queue_byte(1'b1, value, 1'b0);
                // A full screen (or a cursor already past it) pauses, clears and homes.
                if (next_pos >= screen_end)
                begin
                    queue_byte(1'b0, clb_pkg::CMD_CLEAR, 1'b1);
                    queue_byte(1'b0, clb_pkg::CMD_HOME_LINE1, 1'b0);
                    next_pos = '0;
                end
                else if (!one_line && next_pos == 6'(clb_pkg::LINE_LENGTH))
                    queue_byte(1'b0, clb_pkg::CMD_LINE2, 1'b0);
                cursor_pos = next_pos[clb_pkg::POS_W-1:0];
            end
            default:
            begin
            end
        endcase
        tail = beats_due.pop_back();
        tail.last = 1'b1;
        beats_due.push_back(tail);
    endfunction

    // Request acceptance: predict the beats of each request the block takes.
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_request(req_ch.func, req_ch.value);
            reqs_accepted++;
        end
    end

    // Request driver: offers queued requests, with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
            begin
                send_gap     <= $urandom_range(0, 3);
                req_ch.valid <= 1'b0;
            end
            else if (reqs_to_send.size() != 0)
            begin
                lcd_request_t item;
                item = reqs_to_send.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.func  <= item.func;
                req_ch.value <= item.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (!rst_n)
            xfer_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            xfer_ch.ready <= 1'b0;
        end
        else if (!hold_done && reqs_accepted >= HOLD_AFTER)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            xfer_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            xfer_ch.ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            stall_left    <= $urandom_range(0, 3);
            xfer_ch.ready <= 1'b0;
        end
        else
            xfer_ch.ready <= 1'b1;
    end

    // Bus monitor: each beat taken is checked against the oldest expected beat.
    always @(posedge clk)
    begin : watch_bus
        lcd_beat_t due;
        if (rst_n && xfer_ch.valid && xfer_ch.ready)
        begin
            if (beats_due.size() == 0)
                flag_mismatch("beat arrived with nothing expected");
            else
            begin
                due = beats_due.pop_front();
                if (xfer_ch.reg_select !== due.reg_select)
                    flag_mismatch($sformatf("reg_select %b, expected %b",
                                            xfer_ch.reg_select, due.reg_select));
                if (xfer_ch.bus_value !== due.bus_value)
                    flag_mismatch($sformatf("bus_value %h, expected %h",
                                            xfer_ch.bus_value, due.bus_value));
                if (xfer_ch.long_settle !== due.long_settle)
                    flag_mismatch($sformatf("long_settle %b, expected %b",
                                            xfer_ch.long_settle, due.long_settle));
                if (xfer_ch.pause_before !== due.pause_before)
                    flag_mismatch($sformatf("pause_before %b, expected %b",
                                            xfer_ch.pause_before, due.pause_before));
                if (xfer_ch.last !== due.last)
                    flag_mismatch($sformatf("last %b, expected %b", xfer_ch.last, due.last));
            end
        end
    end

    task automatic add_request(input logic [1:0] func, input logic [7:0] value);
        lcd_request_t item;
        item.func  = func;
        item.value = value;
        reqs_to_send.push_back(item);
    endtask

    // Wait until the block has nothing left in flight, then a little longer.
    // The check is made at the rising edge, where the sender's outputs are settled.
    task automatic drain();
        do
            @(posedge clk);
        while (reqs_to_send.size() != 0 || req_ch.valid || beats_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [clb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [clb_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            clb_pkg::REG_FOUR_BIT_MODE: cfg_four_bit = data[0];
            clb_pkg::REG_LINE_COUNT:    cfg_lines    = data;
            default:
            begin
            end
        endcase
    endtask

    // A string start (or a continuation of the current line) and some characters.
    task automatic add_text(input int len, input logic restart);
        if (restart)
            add_request(clb_pkg::FUNC_START, 8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++)
            add_request(clb_pkg::FUNC_CHAR, 8'($urandom_range(0, 255)));
    endtask

    // Stimulus: directed cases first, then random phases under varying settings.
    initial
    begin : stimulus
        logic       mode_tab [NUM_PHASES];
        logic [1:0] lines_tab [NUM_PHASES];
        logic       junk;
        int         added;
        int         pick;
        int         len;
        mode_tab  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        lines_tab = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.func   = clb_pkg::FUNC_INIT;
        req_ch.value  = 8'h00;
        xfer_ch.ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: 8-bit bus, two lines; command bytes around the long-settle bound.
        gap_pct   = 25;
        stall_pct = 25;
        add_request(clb_pkg::FUNC_INIT, 8'hFF);
        add_request(clb_pkg::FUNC_CMD, 8'h00);
        add_request(clb_pkg::FUNC_CMD, 8'h03);
        add_request(clb_pkg::FUNC_CMD, 8'h04);
        add_request(clb_pkg::FUNC_CMD, 8'hFF);
        add_request(clb_pkg::FUNC_START, 8'hAA);
        add_request(clb_pkg::FUNC_CHAR, 8'h00);
        add_request(clb_pkg::FUNC_CHAR, 8'hFF);
        drain();

        // Nibble mode with one line.
        write_reg(clb_pkg::REG_FOUR_BIT_MODE, 2'd1);
        write_reg(clb_pkg::REG_LINE_COUNT, 2'd1);
        add_request(clb_pkg::FUNC_INIT, 8'h00);
        add_request(clb_pkg::FUNC_CMD, 8'h02);
        add_request(clb_pkg::FUNC_CMD, 8'h5A);
        add_request(clb_pkg::FUNC_START, 8'h55);
        add_request(clb_pkg::FUNC_CHAR, 8'h81);
        drain();

        // The remaining function-set variants.
        write_reg(clb_pkg::REG_LINE_COUNT, 2'd2);
        add_request(clb_pkg::FUNC_INIT, 8'h3C);
        drain();
        write_reg(clb_pkg::REG_FOUR_BIT_MODE, 2'd0);
        write_reg(clb_pkg::REG_LINE_COUNT, 2'd1);
        add_request(clb_pkg::FUNC_INIT, 8'hC3);
        drain();

        // Cursor left past the end of a one-line screen by a change of line count.
        write_reg(clb_pkg::REG_LINE_COUNT, 2'd2);
        add_text(20, 1'b1);
        drain();
        write_reg(clb_pkg::REG_LINE_COUNT, 2'd1);
        add_request(clb_pkg::FUNC_CHAR, 8'h41);
        drain();

        // Random phases: mostly strings with random text, some loose commands.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            junk = 1'($urandom_range(0, 1));
            write_reg(clb_pkg::REG_FOUR_BIT_MODE, {junk, mode_tab[p]});
            write_reg(clb_pkg::REG_LINE_COUNT, lines_tab[p]);
            if (p == 2)
                write_reg(REG_SPARE_LO, 2'($urandom_range(0, 3)));
            if (p == 5)
                write_reg(REG_SPARE_HI, 2'($urandom_range(0, 3)));
            if (p == NUM_PHASES - 1 || p % 3 == 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(15, 40);
                stall_pct = $urandom_range(15, 40);
            end
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    // A pick of zero carries on the string already on screen.
                    len = $urandom_range(1, 36);
                    add_text(len, pick != 0);
                    added += len + 1;
                end
                else if (pick < 8)
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_request(clb_pkg::FUNC_CMD, 8'($urandom_range(0, 7)));
                    else
                        add_request(clb_pkg::FUNC_CMD, 8'($urandom_range(0, 255)));
                    added++;
                end
                else if (pick == 8)
                begin
                    add_request(clb_pkg::FUNC_INIT, 8'($urandom_range(0, 255)));
                    added++;
                end
                else
                begin
                    add_request(clb_pkg::FUNC_START, 8'($urandom_range(0, 255)));
                    added++;
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
